// ===== design/pge_pkg.sv =====
`timescale 1ns / 1ps
package pge_pkg;

	localparam int BUF_WORDS   = 64;
	localparam int MAX_MEMBERS = 128;

	localparam int ADDR_W  = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1;
	localparam int OFF_W   = $clog2(BUF_WORDS + 1);
	localparam int LEN_W   = 10;
	localparam int SEQ_W   = 32;
	localparam int CNT_W   = 8;
	localparam int WORD_W  = 64;
	localparam int TDATA_W = 120;

	localparam int QUEUE_DEPTH = 4;
	localparam int QA_W        = $clog2(QUEUE_DEPTH);

	localparam logic [LEN_W-1:0] MAX_BYTES = LEN_W'(BUF_WORDS * 8);

	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Input tdata bit positions.
	localparam int IN_PB_LO  = 64;
	localparam int IN_SEQ_LO = 74;
	localparam int IN_PL_LO  = 106;

	// Output tdata bit positions.
	localparam int OUT_SEQ_LO = 64;
	localparam int OUT_CNT_LO = 96;
	localparam int OUT_LEN_LO = 104;

	typedef struct packed {
		logic              xor_en;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] data;
		logic              emit_en;
		logic [SEQ_W-1:0]  seq;
		logic [CNT_W-1:0]  count;
		logic [LEN_W-1:0]  len;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_XOR_RD,
		BK_XOR_WR,
		BK_EMIT_RD,
		BK_EMIT_LOAD,
		BK_EMIT_ZERO
	} back_state_t;

endpackage

// ===== design/pge_front.sv =====
`timescale 1ns / 1ps
module pge_front import pge_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,
	input  logic               s_axis_tlast,
	input  logic [0:0]         s_axis_tuser,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CNT_W-1:0]   cfg_data,
	input  logic               q_full,
	output logic               q_push,
	output cmd_t               q_cmd
);

	logic [OFF_W-1:0] word_offset_q;
	logic [CNT_W-1:0] member_index_q;
	logic [LEN_W-1:0] parity_length_q;
	logic [SEQ_W-1:0] group_start_q;
	logic [SEQ_W-1:0] group_end_q;
	logic [CNT_W-1:0] group_size_q;

	logic              accept;
	logic              is_data;
	logic              pkt_done;
	logic              xor_en;
	logic              emit_pkt;
	logic              emit_flush;
	logic [WORD_W-1:0] data_word;
	logic [LEN_W-1:0]  packet_bytes;
	logic [SEQ_W-1:0]  packet_seq;
	logic [LEN_W-1:0]  payload_len;
	logic [LEN_W-1:0]  pb_sat;
	logic [LEN_W-1:0]  new_len;
	logic [CNT_W-1:0]  mi_inc;
	logic [CNT_W-1:0]  limit;
	logic [SEQ_W-1:0]  end_new;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign data_word    = s_axis_tdata[WORD_W-1:0];
	assign packet_bytes = s_axis_tdata[IN_PB_LO +: LEN_W];
	assign packet_seq   = s_axis_tdata[IN_SEQ_LO +: SEQ_W];
	assign payload_len  = s_axis_tdata[IN_PL_LO +: LEN_W];

	always_comb begin
		is_data  = (s_axis_tuser[0] == OP_DATA);
		pkt_done = is_data && s_axis_tlast;
		xor_en   = is_data && (word_offset_q < OFF_W'(BUF_WORDS));
		pb_sat   = (packet_bytes > MAX_BYTES) ? MAX_BYTES : packet_bytes;
		new_len  = (pb_sat > parity_length_q) ? pb_sat : parity_length_q;
		mi_inc   = member_index_q + CNT_W'(1);
		end_new  = packet_seq + {{(SEQ_W-LEN_W){1'b0}}, payload_len};
		if (group_size_q == '0) begin
			limit = CNT_W'(1);
		end else if (group_size_q > CNT_W'(MAX_MEMBERS)) begin
			limit = CNT_W'(MAX_MEMBERS);
		end else begin
			limit = group_size_q;
		end
		emit_pkt   = pkt_done && (mi_inc >= limit);
		emit_flush = (s_axis_tuser[0] == OP_FLUSH) && (member_index_q != '0);

		q_cmd.xor_en  = xor_en;
		q_cmd.addr    = word_offset_q[ADDR_W-1:0];
		q_cmd.data    = data_word;
		q_cmd.emit_en = emit_pkt || emit_flush;
		q_cmd.seq     = group_start_q;
		q_cmd.count   = pkt_done ? mi_inc : member_index_q;
		q_cmd.len     = pkt_done ? new_len : parity_length_q;
		q_push        = accept && (xor_en || emit_pkt || emit_flush);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_offset_q   <= '0;
			member_index_q  <= '0;
			parity_length_q <= '0;
			group_start_q   <= '0;
			group_end_q     <= '0;
			group_size_q    <= CNT_W'(4);
		end else begin
			if (cfg_valid && cfg_ready) begin
				group_size_q <= cfg_data;
			end
			if (accept && is_data) begin
				if (s_axis_tlast) begin
					word_offset_q <= '0;
				end else if (xor_en) begin
					word_offset_q <= word_offset_q + OFF_W'(1);
				end
			end
			if (accept && pkt_done) begin
				group_end_q <= end_new;
				if (emit_pkt) begin
					group_start_q   <= end_new;
					member_index_q  <= '0;
					parity_length_q <= '0;
				end else begin
					member_index_q  <= mi_inc;
					parity_length_q <= new_len;
				end
			end
			if (accept && emit_flush) begin
				group_start_q   <= group_end_q;
				member_index_q  <= '0;
				parity_length_q <= '0;
			end
		end
	end

endmodule

// ===== design/pge_queue.sv =====
`timescale 1ns / 1ps
module pge_queue import pge_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_data
);

	cmd_t            slots_q [QUEUE_DEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QA_W:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == (QA_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = slots_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QA_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QA_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QA_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QA_W+1)'(1);
			end
		end
	end

endmodule

// ===== design/pge_back.sv =====
`timescale 1ns / 1ps
module pge_back import pge_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  cmd_t               q_data,
	output logic               q_pop,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tlast
);

	back_state_t state_q;
	back_state_t state_d;
	cmd_t        cmd_q;
	logic [OFF_W-1:0] k_q;

	logic [WORD_W-1:0]    mem [BUF_WORDS];
	logic [BUF_WORDS-1:0] valid_q;
	logic [WORD_W-1:0]    rd_data_q;
	logic                 rd_valid_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic [SEQ_W-1:0]  out_seq_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_last_q;

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic              load_out;
	logic              load_zero;
	logic              clear_valid;
	logic              out_free;
	logic              k_last;
	logic [OFF_W-1:0]  nw_head;
	logic [OFF_W-1:0]  nw_cmd;
	logic [WORD_W-1:0] stored_word;
	logic [WORD_W-1:0] masked_word;

	function automatic logic [OFF_W-1:0] nwords_of(input logic [LEN_W-1:0] len);
		logic [LEN_W:0] sum;
		begin
			sum = {1'b0, len} + (LEN_W+1)'(7);
			return OFF_W'(sum >> 3);
		end
	endfunction

	assign nw_head     = nwords_of(q_data.len);
	assign nw_cmd      = nwords_of(cmd_q.len);
	assign k_last      = (OFF_W'(k_q + OFF_W'(1)) == nw_cmd);
	assign out_free    = !out_valid_q || m_axis_tready;
	assign stored_word = rd_valid_q ? rd_data_q : '0;

	// Only the final word of a run can be partial; bytes past the length read as zero.
	always_comb begin
		masked_word = stored_word;
		for (int i = 0; i < 8; i++) begin
			if (k_last && (cmd_q.len[2:0] != 3'd0) && (3'(i) >= cmd_q.len[2:0])) begin
				masked_word[i*8 +: 8] = 8'h00;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					if (q_data.xor_en) begin
						state_d = BK_XOR_RD;
					end else if (nw_head == '0) begin
						state_d = BK_EMIT_ZERO;
					end else begin
						state_d = BK_EMIT_RD;
					end
				end
			end
			BK_XOR_RD: state_d = BK_XOR_WR;
			BK_XOR_WR: begin
				if (!cmd_q.emit_en) begin
					state_d = BK_IDLE;
				end else if (nw_cmd == '0) begin
					state_d = BK_EMIT_ZERO;
				end else begin
					state_d = BK_EMIT_RD;
				end
			end
			BK_EMIT_RD: state_d = BK_EMIT_LOAD;
			BK_EMIT_LOAD: begin
				if (out_free) begin
					state_d = k_last ? BK_IDLE : BK_EMIT_RD;
				end
			end
			BK_EMIT_ZERO: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop       = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = cmd_q.addr;
		wr_en       = 1'b0;
		load_out    = 1'b0;
		load_zero   = 1'b0;
		clear_valid = 1'b0;
		case (state_q)
			BK_IDLE:    q_pop = q_valid;
			BK_XOR_RD:  rd_en = 1'b1;
			BK_XOR_WR:  wr_en = 1'b1;
			BK_EMIT_RD: begin
				rd_en   = 1'b1;
				rd_addr = k_q[ADDR_W-1:0];
			end
			BK_EMIT_LOAD: begin
				load_out    = out_free;
				clear_valid = out_free && k_last;
			end
			BK_EMIT_ZERO: begin
				load_out    = out_free;
				load_zero   = out_free;
				clear_valid = out_free;
			end
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cmd_q.addr] <= stored_word ^ cmd_q.data;
		end
		if (rd_en) begin
			rd_data_q  <= mem[rd_addr];
			rd_valid_q <= valid_q[rd_addr];
		end
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (load_out) begin
			out_word_q <= load_zero ? '0 : masked_word;
			out_seq_q  <= cmd_q.seq;
			out_cnt_q  <= cmd_q.count;
			out_len_q  <= cmd_q.len;
			out_last_q <= load_zero ? 1'b1 : k_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			k_q         <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				k_q <= '0;
			end else if (load_out) begin
				k_q <= k_q + OFF_W'(1);
			end
			if (clear_valid) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[cmd_q.addr] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		m_axis_tdata                         = '0;
		m_axis_tdata[WORD_W-1:0]             = out_word_q;
		m_axis_tdata[OUT_SEQ_LO +: SEQ_W]    = out_seq_q;
		m_axis_tdata[OUT_CNT_LO +: CNT_W]    = out_cnt_q;
		m_axis_tdata[OUT_LEN_LO +: LEN_W]    = out_len_q;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== design/xor_parity_group_encoder.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Contents
// s_axis    in         s_axis_tvalid/s_axis_tready   packet words and flush requests
// m_axis    out        m_axis_tvalid/m_axis_tready   parity words of one group
// cfg       in         cfg_valid/cfg_ready           group_size
//
// The front takes one request a cycle while its four-entry command queue has room.
// The back takes a data command from the queue, reads the parity memory word, then
// XOR-writes the data word into it; each emitted parity word takes a read and then
// a load of the output register, a pace set by the single memory port.
// Reset needs no clearing pass: per-word valid bits make the parity memory read as zero.
// Either side may stall; the output register holds a parity word until it is taken.
module xor_parity_group_encoder import pge_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// [63:0] data_word, [73:64] packet_bytes, [105:74] packet_seq,
	// [115:106] payload_len, [119:116] zero
	input  logic [TDATA_W-1:0] s_axis_tdata,
	input  logic               s_axis_tlast,
	// [0] operation
	input  logic [0:0]         s_axis_tuser,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// [63:0] parity_word, [95:64] group_seq, [103:96] member_count,
	// [113:104] parity_bytes, [119:114] zero
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tlast,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CNT_W-1:0]   cfg_data
);

	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic q_pop;
	logic q_valid;
	cmd_t q_head;

	pge_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_cmd)
	);

	pge_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_head)
	);

	pge_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
